/* src/otmr_pkg.sv */
// Package for the one-shot timer bank: item structs, entry record, codes.
// No dependencies; used by every module in src.
package otmr_pkg;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_MODIFY = 3'd1;
  localparam logic [2:0] KIND_START  = 3'd2;
  localparam logic [2:0] KIND_DELETE = 3'd3;
  localparam logic [2:0] KIND_TICK   = 3'd4;

  localparam logic [1:0] RES_OK         = 2'd0;
  localparam logic [1:0] RES_BAD_HANDLE = 2'd1;
  localparam logic [1:0] RES_NO_TIMER   = 2'd2;
  localparam logic [1:0] RES_NOT_READY  = 2'd3;

  localparam logic [1:0] ENT_IDLE  = 2'd0;
  localparam logic [1:0] ENT_READY = 2'd1;
  localparam logic [1:0] ENT_RUN   = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  handle;
    logic [31:0] ticks;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] entry;
    logic       expired;
    logic       last;
  } res_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_FLUSH
  } ctrl_state_t;

endpackage

/* src/otmr_cell.sv */
// One timer entry of the ring: status and count, loaded from its neighbor on shift.
// Depends on otmr_pkg.
module otmr_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  otmr_pkg::entry_t d,
  output otmr_pkg::entry_t q
);
  import otmr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.status <= ENT_IDLE;
      q.count  <= 32'd0;
    end else if (shift) begin
      q.status <= d.status;
      q.count  <= d.count;
    end
  end

endmodule

/* src/otmr_ctrl.sv */
// Head of the ring: sequences one operation over all entries as they pass,
// updates each entry and builds the result items. Depends on otmr_pkg.
module otmr_ctrl #(
  parameter int NUM_TIMERS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  otmr_pkg::cmd_item_t cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output otmr_pkg::res_item_t res,
  input  otmr_pkg::entry_t    head,
  output otmr_pkg::entry_t    tail,
  output logic               shift
);
  import otmr_pkg::*;

  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [SW-1:0] LAST_STEP = SW'(NUM_TIMERS - 1);

  ctrl_state_t state, state_next;
  cmd_item_t   op, op_next;
  logic [SW-1:0] step, step_next;
  logic        found, found_next;
  logic        pend_valid, pend_valid_next;
  res_item_t   pend, pend_next;
  logic        out_valid, out_valid_next;
  res_item_t   out, out_next;

  logic        out_free;
  logic        hit;
  logic        blocked;
  logic [31:0] dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CS_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      found      <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      found      <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    op   <= op_next;
    step <= step_next;
    pend <= pend_next;
    out  <= out_next;
  end

  assign cmd_stall = (state != CS_IDLE);
  assign res_valid = out_valid;
  assign res       = out;
  assign out_free  = !out_valid || !res_stall;
  assign hit       = (op.handle == 8'(step));
  assign dec       = head.count - 32'd1;

  always_comb begin
    state_next      = state;
    op_next         = op;
    step_next       = step;
    found_next      = found;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    out_valid_next  = out_valid && res_stall;
    out_next        = out;
    tail            = head;
    shift           = 1'b0;
    blocked         = 1'b0;

    unique case (state)
      CS_IDLE: begin
        if (cmd_valid) begin
          op_next    = cmd;
          step_next  = '0;
          found_next = 1'b0;
          pend_next  = '{status: RES_BAD_HANDLE, entry: 6'd0, expired: 1'b0, last: 1'b1};
          unique case (cmd.kind)
            KIND_TICK: begin
              pend_valid_next = 1'b0;
              state_next      = CS_SCAN;
            end
            KIND_ADD: begin
              pend_valid_next  = 1'b1;
              pend_next.status = RES_NO_TIMER;
              state_next       = CS_SCAN;
            end
            KIND_MODIFY, KIND_START, KIND_DELETE: begin
              pend_valid_next = 1'b1;
              state_next      = CS_SCAN;
            end
            default: begin
              pend_valid_next = 1'b0;
            end
          endcase
        end
      end

      CS_SCAN: begin
        unique case (op.kind)
          KIND_ADD: begin
            if (!found && head.status == ENT_IDLE) begin
              tail.status      = ENT_READY;
              tail.count       = op.ticks;
              found_next       = 1'b1;
              pend_next.status = RES_OK;
              pend_next.entry  = 6'(step);
            end
          end
          KIND_MODIFY: begin
            if (hit) begin
              if (head.status == ENT_IDLE) begin
                pend_next.status = RES_NO_TIMER;
              end else begin
                tail.count       = op.ticks;
                pend_next.status = RES_OK;
              end
            end
          end
          KIND_START: begin
            if (hit) begin
              if (head.status == ENT_READY) begin
                tail.status      = ENT_RUN;
                pend_next.status = RES_OK;
              end else begin
                pend_next.status = RES_NOT_READY;
              end
            end
          end
          KIND_DELETE: begin
            if (hit && head.status != ENT_IDLE) begin
              tail.status      = ENT_IDLE;
              tail.count       = 32'd0;
              pend_next.status = RES_OK;
            end
          end
          default: begin
            // tick
            if (head.status == ENT_RUN) begin
              tail.count = dec;
              if (dec == 32'd0) begin
                if (pend_valid && !out_free) begin
                  blocked = 1'b1;
                end else begin
                  tail.status = ENT_IDLE;
                  if (pend_valid) begin
                    out_valid_next = 1'b1;
                    out_next       = pend;
                    out_next.last  = 1'b0;
                  end
                  pend_valid_next = 1'b1;
                  pend_next = '{status: RES_OK, entry: 6'(step), expired: 1'b1, last: 1'b1};
                end
              end
            end
          end
        endcase

        if (blocked) begin
          tail            = head;
          found_next      = found;
          pend_next       = pend;
          pend_valid_next = pend_valid;
        end else begin
          shift     = 1'b1;
          step_next = step + SW'(1);
          if (step == LAST_STEP) begin
            state_next = CS_FLUSH;
          end
        end
      end

      CS_FLUSH: begin
        if (!pend_valid) begin
          state_next = CS_IDLE;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_next        = pend;
          out_next.last   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = CS_IDLE;
        end
      end

      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

/* src/one_shot_timer_table_unit.sv */
// One-shot timer bank: NUM_TIMERS entries held in a ring of cells that rotates
// once past a single head unit for every add, modify, start, delete or tick
// item: the item is accepted, each entry is updated as it passes the head, and
// the final result is handed over, which waits while the output register is
// stalled; kinds 5 to 7 are accepted without effect. A tick stalls
// its rotation while a finished expiry cannot be handed to the output register.
// Results are one item per add, modify, start or delete, or one per expired timer
// in index order on tick, with last set on the final one.
module one_shot_timer_table_unit #(
  parameter int NUM_TIMERS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  otmr_pkg::cmd_item_t cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output otmr_pkg::res_item_t res
);
  import otmr_pkg::*;

  entry_t ring [NUM_TIMERS];
  entry_t tail;
  logic   shift;

  otmr_ctrl #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .head      (ring[0]),
    .tail      (tail),
    .shift     (shift)
  );

  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    entry_t d;
    if (k == NUM_TIMERS - 1) begin : g_last
      assign d = tail;
    end else begin : g_mid
      assign d = ring[k+1];
    end
    otmr_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (ring[k])
    );
  end

endmodule

/* verif/tb.sv */
// Self-checking testbench for one_shot_timer_table_unit: directed then random command items,
// with an in-bench timer bank model that predicts every result item.
// Depends on otmr_pkg and the unit in src.
`timescale 1ns / 100ps

module tb;
  import otmr_pkg::*;

  localparam int NUM_TIMERS = 8;
  localparam int ITEM_TOTAL = 460;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;

  typedef struct {
    cmd_item_t c;
    bit        drain;
    bit        tight;
  } cmd_plan_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_item_t cmd = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res;

  cmd_plan_t   plan_q[$];
  res_item_t   due_results[$];
  logic [1:0]  bank_state[NUM_TIMERS] = '{default: ENT_IDLE};
  logic [31:0] bank_count[NUM_TIMERS] = '{default: 32'd0};

  logic        cmd_fire = 1'b0;
  int          cycles = 0;
  int          errors = 0;
  int          cmds_taken = 0;
  int          results_seen = 0;
  int          expiries = 0;
  int          refused_adds = 0;

  one_shot_timer_table_unit #(.NUM_TIMERS(NUM_TIMERS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned draw_gap(bit tight);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tight || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic plan(input logic [2:0] k, input logic [7:0] h, input logic [31:0] t,
                      input bit drain = 1'b0, input bit tight = 1'b0);
    cmd_plan_t p;
    p.c.kind = k;
    p.c.handle = h;
    p.c.ticks = t;
    p.drain = drain;
    p.tight = tight;
    plan_q.push_back(p);
  endtask

  // Bank model: updates the shadow entries and queues the result items one command causes.
  task automatic timer_bank_apply(input cmd_item_t c);
    res_item_t r;
    int i;
    int hits;
    bit placed;
    bit answers;
    r = '0;
    r.last = 1'b1;
    hits = 0;
    placed = 1'b0;
    answers = 1'b1;
    case (c.kind)
      KIND_ADD: begin
        r.status = RES_NO_TIMER;
        for (i = 0; i < NUM_TIMERS; i++) begin
          if (!placed && bank_state[i] == ENT_IDLE) begin
            placed = 1'b1;
            bank_state[i] = ENT_READY;
            bank_count[i] = c.ticks;
            r.status = RES_OK;
            r.entry = 6'(i);
          end
        end
        if (!placed) refused_adds++;
      end
      KIND_MODIFY: begin
        if (c.handle >= NUM_TIMERS) r.status = RES_BAD_HANDLE;
        else if (bank_state[c.handle] == ENT_IDLE) r.status = RES_NO_TIMER;
        else bank_count[c.handle] = c.ticks;
      end
      KIND_START: begin
        if (c.handle >= NUM_TIMERS) r.status = RES_BAD_HANDLE;
        else if (bank_state[c.handle] != ENT_READY) r.status = RES_NOT_READY;
        else bank_state[c.handle] = ENT_RUN;
      end
      KIND_DELETE: begin
        if (c.handle >= NUM_TIMERS || bank_state[c.handle] == ENT_IDLE) begin
          r.status = RES_BAD_HANDLE;
        end else begin
          bank_state[c.handle] = ENT_IDLE;
          bank_count[c.handle] = 32'd0;
        end
      end
      KIND_TICK: begin
        answers = 1'b0;
        for (i = 0; i < NUM_TIMERS; i++) begin
          if (bank_state[i] == ENT_RUN) begin
            bank_count[i] = bank_count[i] - 32'd1;
            if (bank_count[i] == 32'd0) begin
              bank_state[i] = ENT_IDLE;
              if (hits > 0) due_results[due_results.size() - 1].last = 1'b0;
              r = '0;
              r.entry = 6'(i);
              r.expired = 1'b1;
              r.last = 1'b1;
              due_results.push_back(r);
              hits++;
            end
          end
        end
      end
      default: answers = 1'b0;
    endcase
    if (answers) due_results.push_back(r);
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Command driver, fed from plan_q.
  logic        drv_valid;
  cmd_item_t   drv_cmd;
  int unsigned gap_left = 0;
  bit          head_tight = 1'b0;
  cmd_plan_t   head;

  always @(negedge clk) begin
    drv_valid = cmd_valid;
    drv_cmd = cmd;
    if (!rst) begin
      if (cmd_valid && cmd_fire) begin
        drv_valid = 1'b0;
        gap_left = draw_gap(head_tight);
      end
      if (!drv_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (plan_q.size() > 0 && !(plan_q[0].drain && due_results.size() != 0)) begin
          head = plan_q.pop_front();
          drv_cmd = head.c;
          head_tight = head.tight;
          drv_valid = 1'b1;
        end
      end
    end
    cmd_valid <= drv_valid;
    cmd <= drv_cmd;
  end

  // Result-side backpressure, with calm stretches.
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (stall_left == 0 && (cycles / 1500) % 4 != 1 && $urandom_range(0, 99) < 35) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    end
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Monitor: predicts on accepted commands, checks accepted results.
  res_item_t want;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    cmd_fire <= !rst && cmd_valid && !cmd_stall;
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        timer_bank_apply(cmd);
        cmds_taken++;
      end
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result expected none got status %0d entry %0d expired %0b last %0b",
                   $time, res.status, res.entry, res.expired, res.last);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, res.status);
          check_field("entry", want.entry, res.entry);
          check_field("expired", want.expired, res.expired);
          check_field("last", want.last, res.last);
          results_seen++;
          if (want.expired) expiries++;
        end
      end
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  int          n;
  int          live;
  int unsigned r;
  int unsigned s;
  logic [2:0]  k;
  logic [7:0]  h;
  logic [31:0] t;
  logic [31:0] fill_ticks[8] = '{32'd1, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'd1, 32'd3, 32'd1, 32'd2};

  initial begin
    plan(KIND_TICK, 8'd0, 32'd0);
    plan(KIND_ADD, 8'd0, 32'd0);
    plan(KIND_START, 8'd0, 32'd0);
    plan(KIND_TICK, 8'd0, 32'd0);            // zero count wraps, no expiry
    plan(KIND_START, 8'd0, 32'd0);           // running: not ready
    plan(KIND_DELETE, 8'd0, 32'd0);
    plan(KIND_DELETE, 8'd0, 32'd0);          // idle: bad handle
    plan(KIND_MODIFY, 8'd0, 32'd5);          // idle: no timer
    plan(KIND_START, 8'd0, 32'd0);           // idle: not ready
    for (n = 0; n < NUM_TIMERS; n++) plan(KIND_ADD, 8'hFF, fill_ticks[n]);
    plan(KIND_ADD, 8'd0, 32'd7, 1'b1);       // full bank
    plan(KIND_MODIFY, 8'hFF, 32'hAAAA_5555);
    plan(KIND_START, 8'(NUM_TIMERS), 32'd0);
    plan(KIND_DELETE, 8'hC8, 32'd0);
    plan(KIND_MODIFY, 8'd3, 32'd1);
    plan(KIND_SPARE_A, 8'd1, 32'hFFFF_FFFF);
    plan(KIND_SPARE_C, 8'd2, 32'd0);
    plan(KIND_START, 8'd0, 32'd0);
    plan(KIND_START, 8'd1, 32'd0);
    plan(KIND_START, 8'd3, 32'd0);
    plan(KIND_START, 8'd7, 32'd0);
    plan(KIND_TICK, 8'd0, 32'd0);            // several expiries in one tick

    live = 0;
    for (n = 0; live < ITEM_TOTAL - 31; n++) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      h = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, NUM_TIMERS - 1));
      t = (s < 80) ? 32'($urandom_range(1, 6)) : (s < 88) ? 32'd0 : $urandom();
      if (r < 22) k = KIND_ADD;
      else if (r < 32) k = KIND_MODIFY;
      else if (r < 54) k = KIND_START;
      else if (r < 66) k = KIND_DELETE;
      else if (r < 96) k = KIND_TICK;
      else k = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
      if (k <= KIND_TICK) live++;
      plan(k, h, t, n % 90 == 89, n >= 150 && n < 240);
    end

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    wait (plan_q.size() == 0 && !cmd_valid);
    wait (due_results.size() == 0);
    repeat (3 * NUM_TIMERS + 10) @(posedge clk);

    $display("tb: %0d commands taken, %0d results checked", cmds_taken, results_seen);
    $display("tb: %0d timer expiries, %0d adds refused on a full bank", expiries, refused_adds);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
